[hdl/dma_channel_register_bank_defines.svh]
// Assertion macros used by the checker of the DMA channel register bank.
`ifndef DMA_CHANNEL_REGISTER_BANK_DEFINES_SVH
`define DMA_CHANNEL_REGISTER_BANK_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst is high.
`define DCRB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst is high.
`define DCRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/dcrb_pkg.sv]
// Shared constants, register map and helper function of the DMA channel register bank.
`default_nettype none

package dcrb_pkg;

  localparam int unsigned CHANNELS_DEF          = 8;
  localparam int unsigned WORDS_PER_CHANNEL_DEF = 16;
  localparam int unsigned DATA_W                = 32;
  localparam int unsigned ADDR_W                = 12;
  localparam int unsigned BYTES_W               = 3;
  localparam int unsigned IRQ_W                 = 8;

  localparam logic [DATA_W-1:0] ID_WORD  = 32'hD4A0_0100;
  localparam logic [DATA_W-1:0] CAP_BASE = 32'h0001_0400;

  // Global words sit in the last page of the window.
  localparam logic [ADDR_W-1:0] GLB_BASE = 12'hF00;
  localparam logic [3:0]        GLB_PAGE = 4'hF;

  // Global word numbers within the page (address bits 7:2).
  localparam logic [5:0] G_IRQ_STAT   = 6'd0;
  localparam logic [5:0] G_IRQ_EN     = 6'd1;
  localparam logic [5:0] G_ID         = 6'd2;
  localparam logic [5:0] G_CAP        = 6'd3;
  localparam logic [5:0] G_PERF_CTRL  = 6'd4;
  localparam logic [5:0] G_PERF_CYC   = 6'd5;
  localparam logic [5:0] G_PERF_RD    = 6'd6;
  localparam logic [5:0] G_PERF_WR    = 6'd7;

  // Word numbers within a channel.
  localparam int unsigned W_CTRL     = 0;
  localparam int unsigned W_STAT     = 1;
  localparam int unsigned W_SRC      = 2;
  localparam int unsigned W_XFER     = 4;
  localparam int unsigned W_ROWCNT   = 7;
  localparam int unsigned W_PLANECNT = 10;

  // Control and status bits.
  localparam int unsigned CTRL_START_B = 1;
  localparam int unsigned CTRL_MODE_LO = 3;
  localparam int unsigned CTRL_IE_B    = 7;
  localparam int unsigned PERF_EN_B    = 0;
  localparam int unsigned PERF_CLR_B   = 1;

  localparam logic [DATA_W-1:0] CTRL_START_M = 32'h0000_0002;
  localparam logic [DATA_W-1:0] STAT_BUSY_M  = 32'h0000_0001;
  localparam logic [DATA_W-1:0] STAT_DONE_M  = 32'h0000_0002;
  localparam logic [DATA_W-1:0] STAT_ERR_M   = 32'h0000_0004;

  localparam logic [1:0] MODE_ROWS   = 2'd1;
  localparam logic [1:0] MODE_PLANES = 2'd2;

  // Byte lane mask for an access width; zero bytes gives an empty mask.
  function automatic logic [DATA_W-1:0] width_mask(input logic [BYTES_W-1:0] n);
    logic [DATA_W-1:0] m;
    case (n)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

[hdl/dcrb_word_ram.sv]
// Channel word memory with one write port, one registered read port and per-entry valid bits.
`default_nettype none

module dcrb_word_ram
  import dcrb_pkg::*;
#(
  parameter int unsigned DEPTH = CHANNELS_DEF * WORDS_PER_CHANNEL_DEF,
  localparam int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [IDX_W-1:0]  raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  written;
  logic [DATA_W-1:0] mem_q;
  logic              hit_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      hit_q <= written[raddr];
    end
  end

  assign rdata = hit_q ? mem_q : '0;

endmodule

`default_nettype wire

[hdl/dma_channel_register_bank.sv]
// Register bank of an eight-channel DMA controller, serving one bus transfer at a time.
// A plain read or write goes through EXEC and FINISH before the next acceptance; its
// result is registered in FINISH. A CTRL write with START also walks the five sequential
// reads of the single channel word memory port and the two byte-count multiplies.
// Synchronous reset empties the bank: every channel word reads zero at once.
`default_nettype none

module dma_channel_register_bank
  import dcrb_pkg::*;
#(
  parameter int unsigned CHANNELS          = CHANNELS_DEF,
  parameter int unsigned WORDS_PER_CHANNEL = WORDS_PER_CHANNEL_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [ADDR_W-1:0]  address,
  input  logic [BYTES_W-1:0] access_bytes,
  input  logic [DATA_W-1:0]  write_data,
  input  logic               mem_fault,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DATA_W-1:0]  read_data,
  output logic               access_error,
  output logic               irq_level
);

  localparam int unsigned DEPTH  = CHANNELS * WORDS_PER_CHANNEL;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned WORD_W = $clog2(WORDS_PER_CHANNEL);

  // First byte offset past the channel area; from there up to the global page is a hole.
  localparam logic [ADDR_W-1:0] CH_LIMIT  = ADDR_W'(DEPTH * 4);
  localparam logic [IDX_W-1:0]  WORD_MASK = IDX_W'(WORDS_PER_CHANNEL - 1);
  localparam logic [DATA_W-1:0] CAP_WORD  = CAP_BASE | DATA_W'(CHANNELS);

  // The sequencer walks one transfer through the memory. A plain access needs only
  // EXEC; a start fetches SRC, XFER, ROWCNT, PLANECNT and STAT in turn, one word per
  // cycle, then writes STAT back and updates the byte counters.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SRC,
    ST_XFER,
    ST_ROW,
    ST_PLANE,
    ST_STAT,
    ST_PERF,
    ST_FINISH
  } state_t;

  state_t state;

  // The accepted transfer, held until its result has been handed over.
  logic              op_write;
  logic [ADDR_W-1:0] op_addr;
  logic [DATA_W-1:0] op_mask;
  logic [DATA_W-1:0] op_data;
  logic              op_fault;
  logic              op_err;
  logic [DATA_W-1:0] rd_val;

  // Operands of a started transfer.
  logic              src_zero;
  logic [DATA_W-1:0] xfer;
  logic [DATA_W-1:0] rows;
  logic [DATA_W-1:0] planes;
  logic [DATA_W-1:0] prod_rows;
  logic [DATA_W-1:0] prod_planes;

  // Global registers.
  logic [IRQ_W-1:0]  irq_status;
  logic [DATA_W-1:0] irq_enable;
  logic              perf_enable;
  logic [DATA_W-1:0] perf_cycles;
  logic [DATA_W-1:0] perf_read_bytes;
  logic [DATA_W-1:0] perf_write_bytes;

  // Memory port.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Decode of the held transfer.
  logic              in_err;
  logic [IDX_W-1:0]  op_idx;
  logic [IDX_W-1:0]  ch_base;
  logic [WORD_W-1:0] op_word;
  logic [2:0]        op_ch;
  logic              op_global;
  logic [5:0]        glb_sel;
  logic [DATA_W-1:0] glb_rdata;
  logic [DATA_W-1:0] stat_clr;
  logic [1:0]        ctrl_mode;
  logic              xfer_err;
  logic [DATA_W-1:0] byte_count;
  logic [IDX_W-1:0]  idx_src;
  logic [IDX_W-1:0]  idx_xfer;
  logic [IDX_W-1:0]  idx_rows;
  logic [IDX_W-1:0]  idx_planes;
  logic [IDX_W-1:0]  idx_stat;

  dcrb_word_ram #(
    .DEPTH (DEPTH)
  ) u_word_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Only the idle sequencer takes a transfer; a finished result waiting in the
  // output register does not hold up the next one.
  assign in_stall = rst || (state != ST_IDLE);

  // Misaligned, or in the hole between the channel area and the global page.
  assign in_err = (address[1:0] != 2'b00) || ((address >= CH_LIMIT) && (address < GLB_BASE));

  assign op_idx    = op_addr[IDX_W+1:2];
  assign op_word   = op_addr[WORD_W+1:2];
  assign op_ch     = op_addr[WORD_W+4:WORD_W+2];
  assign op_global = (op_addr[ADDR_W-1:8] == GLB_PAGE);
  assign glb_sel   = op_addr[7:2];
  assign ch_base   = op_idx & ~WORD_MASK;

  assign idx_src    = ch_base | IDX_W'(W_SRC);
  assign idx_xfer   = ch_base | IDX_W'(W_XFER);
  assign idx_rows   = ch_base | IDX_W'(W_ROWCNT);
  assign idx_planes = ch_base | IDX_W'(W_PLANECNT);
  assign idx_stat   = ch_base | IDX_W'(W_STAT);

  assign stat_clr  = op_data & (STAT_DONE_M | STAT_ERR_M);
  assign ctrl_mode = op_data[CTRL_MODE_LO+1:CTRL_MODE_LO];
  assign xfer_err  = src_zero || op_fault;

  always_comb begin
    case (glb_sel)
      G_IRQ_STAT:  glb_rdata = DATA_W'(irq_status);
      G_IRQ_EN:    glb_rdata = irq_enable;
      G_ID:        glb_rdata = ID_WORD;
      G_CAP:       glb_rdata = CAP_WORD;
      G_PERF_CTRL: glb_rdata = DATA_W'(perf_enable);
      G_PERF_CYC:  glb_rdata = perf_cycles;
      G_PERF_RD:   glb_rdata = perf_read_bytes;
      G_PERF_WR:   glb_rdata = perf_write_bytes;
      default:     glb_rdata = '0;
    endcase
  end

  // Mode-scaled byte count; a zero row or plane count falls back to XFER alone.
  always_comb begin
    if ((ctrl_mode == MODE_ROWS) && (rows != '0)) begin
      byte_count = prod_rows;
    end else if ((ctrl_mode == MODE_PLANES) && (rows != '0) && (planes != '0)) begin
      byte_count = prod_planes;
    end else begin
      byte_count = xfer;
    end
  end

  // Memory addressing. The word named by the incoming address is read while the
  // sequencer idles, so that EXEC already has it for a read or a STAT clear. Every
  // write lands before any read of the same word is issued, so no forwarding is
  // needed.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = op_idx;
    ram_wdata = op_data;
    ram_raddr = op_idx;
    case (state)
      ST_IDLE: begin
        ram_raddr = address[IDX_W+1:2];
      end
      ST_EXEC: begin
        ram_raddr = idx_src;
        if (!op_err && !op_global && op_write) begin
          ram_we = 1'b1;
          if (op_word == WORD_W'(W_STAT)) begin
            ram_wdata = ram_rdata & ~stat_clr;
          end else if (op_word == WORD_W'(W_CTRL)) begin
            ram_wdata = op_data & ~CTRL_START_M;
          end
        end
      end
      ST_SRC: begin
        ram_raddr = idx_xfer;
      end
      ST_XFER: begin
        ram_raddr = idx_rows;
      end
      ST_ROW: begin
        ram_raddr = idx_planes;
      end
      ST_PLANE: begin
        ram_raddr = idx_stat;
      end
      ST_STAT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_stat;
        ram_wdata = (ram_rdata & ~STAT_BUSY_M) | (xfer_err ? STAT_ERR_M : STAT_DONE_M);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      irq_status       <= '0;
      irq_enable       <= '0;
      perf_enable      <= 1'b0;
      perf_cycles      <= '0;
      perf_read_bytes  <= '0;
      perf_write_bytes <= '0;
    end else begin
      // In FINISH the output register is reloaded instead.
      if (out_valid && !out_stall && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_write <= func;
            op_addr  <= address;
            op_mask  <= width_mask(access_bytes);
            op_data  <= write_data & width_mask(access_bytes);
            op_fault <= mem_fault;
            op_err   <= in_err;
            state    <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (!op_err && !op_global && op_write && (op_word == WORD_W'(W_CTRL)) &&
              op_data[CTRL_START_B]) begin
            state <= ST_SRC;
          end else begin
            state <= ST_FINISH;
          end
          if (op_err || op_write) begin
            rd_val <= '0;
          end else if (op_global) begin
            rd_val <= glb_rdata & op_mask;
          end else begin
            rd_val <= ram_rdata & op_mask;
          end
          if (!op_err && op_write) begin
            if (op_global) begin
              case (glb_sel)
                G_IRQ_STAT: irq_status <= irq_status & ~op_data[IRQ_W-1:0];
                G_IRQ_EN:   irq_enable <= op_data;
                G_PERF_CTRL: begin
                  if (op_data[PERF_CLR_B]) begin
                    perf_cycles      <= '0;
                    perf_read_bytes  <= '0;
                    perf_write_bytes <= '0;
                  end
                  perf_enable <= op_data[PERF_EN_B];
                end
                G_PERF_CYC: perf_cycles      <= op_data;
                G_PERF_RD:  perf_read_bytes  <= op_data;
                G_PERF_WR:  perf_write_bytes <= op_data;
                default: begin
                end
              endcase
            end else if (op_word == WORD_W'(W_STAT)) begin
              if (stat_clr != '0) begin
                irq_status[op_ch] <= 1'b0;
              end
            end
          end
        end
        ST_SRC: begin
          src_zero <= (ram_rdata == '0);
          state    <= ST_XFER;
        end
        ST_XFER: begin
          xfer  <= ram_rdata;
          state <= ST_ROW;
        end
        ST_ROW: begin
          rows  <= ram_rdata;
          state <= ST_PLANE;
        end
        ST_PLANE: begin
          planes    <= ram_rdata;
          prod_rows <= xfer * rows;
          state     <= ST_STAT;
        end
        ST_STAT: begin
          prod_planes <= prod_rows * planes;
          if (op_data[CTRL_IE_B]) begin
            irq_status[op_ch] <= 1'b1;
          end
          state <= ST_PERF;
        end
        ST_PERF: begin
          if (!xfer_err && perf_enable) begin
            perf_read_bytes  <= perf_read_bytes + byte_count;
            perf_write_bytes <= perf_write_bytes + byte_count;
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          // All state updates of this transfer are in place, so the interrupt
          // level reflects the bank after the access.
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            read_data    <= rd_val;
            access_error <= op_err;
            irq_level    <= |(irq_status & irq_enable[IRQ_W-1:0]);
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/dcrb_checker.sv]
// Port-level checker of the DMA channel register bank and its bind to the top level.
`default_nettype none

`include "dma_channel_register_bank_defines.svh"

module dcrb_checker
  import dcrb_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               func,
  input wire logic [ADDR_W-1:0]  address,
  input wire logic [BYTES_W-1:0] access_bytes,
  input wire logic [DATA_W-1:0]  write_data,
  input wire logic               mem_fault,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [DATA_W-1:0]  read_data,
  input wire logic               access_error,
  input wire logic               irq_level
);

  logic                              in_wait;
  logic                              out_wait;
  logic [ADDR_W+BYTES_W+DATA_W+1:0]  in_word;
  logic [DATA_W+1:0]                 out_word;

  assign in_wait  = in_valid && in_stall;
  assign out_wait = out_valid && out_stall;
  assign in_word  = {func, address, access_bytes, write_data, mem_fault};
  assign out_word = {read_data, access_error, irq_level};

  // A stalled result stays offered and unchanged.
  `DCRB_ASSERT_NEXT(a_result_held, out_wait, out_valid && $stable(out_word), "result changed")

  // A stalled transfer on the input side stays offered and unchanged.
  `DCRB_ASSERT_NEXT(a_input_held, in_wait, in_valid && $stable(in_word), "input changed")

  // An errored access returns no data.
  `DCRB_ASSERT_IMPL(a_error_no_data, out_valid && access_error, read_data == '0, "data on error")

  // One transfer at a time: the bank is busy in the cycle after it accepts one.
  `DCRB_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no stall after accept")

  // No result is offered straight after reset.
  `DCRB_ASSERT_IMPL(a_empty_after_reset, $past(rst), !out_valid, "result offered after reset")

endmodule

bind dma_channel_register_bank dcrb_checker u_dcrb_checker (.*);

`default_nettype wire
